// File: sv/twcbr_pkg.sv
// shared types and constants for the two-way byte read cache
// address split, request record and queue sizing; no dependencies
package twcbr_pkg;

    // geometry
    localparam int NUM_SETS   = 32;
    localparam int ADDR_BITS  = 20;
    localparam int OFF_BITS   = 2;
    localparam int SET_BITS   = $clog2(NUM_SETS);
    localparam int TAG_BITS   = ADDR_BITS - SET_BITS - OFF_BITS;
    localparam int WORD_BITS  = 32;
    localparam int BYTE_BITS  = 8;
    localparam int BYTE_SHIFT = $clog2(BYTE_BITS);

    // queue between front and back
    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_BITS = $clog2(Q_DEPTH);
    localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

    // decoded request
    typedef struct packed {
        logic [TAG_BITS-1:0]  tag;
        logic [SET_BITS-1:0]  set_idx;
        logic [OFF_BITS-1:0]  offset;
        logic [WORD_BITS-1:0] word;
    } t_req;

    // one cache line with its tag
    typedef struct packed {
        logic [TAG_BITS-1:0]  tag;
        logic [WORD_BITS-1:0] data;
    } t_line;

endpackage

// File: sv/twcbr_front.sv
// front end: takes a request transfer, splits the address, hands it to the queue
// depends on twcbr_pkg
module twcbr_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [twcbr_pkg::ADDR_BITS-1:0] i_phys_address,
    input  logic [twcbr_pkg::WORD_BITS-1:0] i_memory_word,
    input  logic                          i_q_full,
    output logic                          o_busy,
    output logic                          o_push,
    output twcbr_pkg::t_req               o_req
);
    import twcbr_pkg::*;

    logic r_req_vld;
    logic n_req_vld;
    t_req r_req;
    logic accept;

    // hold off only when the staging register cannot drain
    assign o_busy = r_req_vld && i_q_full;
    assign o_push = r_req_vld && !i_q_full;
    assign accept = i_start && !o_busy;
    assign o_req  = r_req;

    // staging register occupancy
    always_comb begin
        if (accept) begin
            n_req_vld = 1'b1;
        end else if (o_push) begin
            n_req_vld = 1'b0;
        end else begin
            n_req_vld = r_req_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_vld <= 1'b0;
        end else begin
            r_req_vld <= n_req_vld;
        end
    end

    // address split into tag, set and byte offset
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req.tag     <= i_phys_address[ADDR_BITS-1 -: TAG_BITS];
            r_req.set_idx <= i_phys_address[OFF_BITS +: SET_BITS];
            r_req.offset  <= i_phys_address[OFF_BITS-1:0];
            r_req.word    <= i_memory_word;
        end
    end

endmodule

// File: sv/twcbr_queue.sv
// small in-order queue of decoded requests between front and back
// depends on twcbr_pkg
module twcbr_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  twcbr_pkg::t_req i_data,
    input  logic            i_pop,
    output twcbr_pkg::t_req o_data,
    output logic            o_full,
    output logic            o_empty
);
    import twcbr_pkg::*;

    t_req                  r_mem [Q_DEPTH];
    logic [Q_PTR_BITS-1:0] r_wr_ptr;
    logic [Q_PTR_BITS-1:0] r_rd_ptr;
    logic [Q_CNT_BITS-1:0] r_count;
    logic [Q_CNT_BITS-1:0] n_count;

    assign o_full  = (r_count == Q_CNT_BITS'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    // occupancy update
    always_comb begin
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == Q_PTR_BITS'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == Q_PTR_BITS'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // checks
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push) else $error("push into a full queue");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop) else $error("pop from an empty queue");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= Q_CNT_BITS'(Q_DEPTH)) else $error("queue count out of range");

endmodule

// File: sv/twcbr_back.sv
// back end: tag lookup in both ways, byte select, miss fill and replacement
// depends on twcbr_pkg; holds the tag and data arrays of both ways
module twcbr_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_empty,
    input  twcbr_pkg::t_req               i_q_data,
    output logic                          o_pop,
    output logic                          o_strobe,
    output logic [twcbr_pkg::BYTE_BITS-1:0] o_data_byte,
    output logic                          o_from_memory
);
    import twcbr_pkg::*;

    typedef enum logic [1:0] {
        B_IDLE = 2'b01,
        B_LOOK = 2'b10
    } t_bstate;

    t_bstate r_state;
    t_bstate n_state;

    t_line r_way0 [NUM_SETS];
    t_line r_way1 [NUM_SETS];
    logic [1:0] r_way_valid [NUM_SETS];
    logic       r_last_fill [NUM_SETS];

    t_req  r_work;
    t_line r_rd0;
    t_line r_rd1;

    logic                 r_strobe;
    logic [BYTE_BITS-1:0] r_data_byte;
    logic                 r_from_memory;

    logic [1:0]           cur_valid;
    logic                 hit0;
    logic                 hit1;
    logic                 miss;
    logic                 victim;
    logic                 fill;
    logic [WORD_BITS-1:0] sel_word;

    assign o_pop = (r_state == B_IDLE) && !i_q_empty;

    // sequencer: read arrays, then compare and fill
    always_comb begin
        unique case (r_state)
            B_IDLE:  n_state = o_pop ? B_LOOK : B_IDLE;
            B_LOOK:  n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // registered read of both ways at the request's set
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_work <= i_q_data;
            r_rd0  <= r_way0[i_q_data.set_idx];
            r_rd1  <= r_way1[i_q_data.set_idx];
        end
    end

    // hit detection, victim choice, fill enable and word select
    always_comb begin
        cur_valid = r_way_valid[r_work.set_idx];
        hit0      = cur_valid[0] && (r_rd0.tag == r_work.tag);
        hit1      = cur_valid[1] && (r_rd1.tag == r_work.tag);
        miss      = !hit0 && !hit1;
        if (!cur_valid[0]) begin
            victim = 1'b0;
        end else if (!cur_valid[1]) begin
            victim = 1'b1;
        end else begin
            victim = !r_last_fill[r_work.set_idx];
        end
        fill = (r_state == B_LOOK) && miss;
        if (hit0) begin
            sel_word = r_rd0.data;
        end else if (hit1) begin
            sel_word = r_rd1.data;
        end else begin
            sel_word = r_work.word;
        end
    end

    // line fill on a miss
    always_ff @(posedge i_clk) begin
        if (fill) begin
            if (victim) begin
                r_way1[r_work.set_idx] <= '{tag: r_work.tag, data: r_work.word};
            end else begin
                r_way0[r_work.set_idx] <= '{tag: r_work.tag, data: r_work.word};
            end
        end
    end

    // valid bits and replacement order
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NUM_SETS; s++) begin
                r_way_valid[s] <= 2'b00;
                r_last_fill[s] <= 1'b0;
            end
        end else if (fill) begin
            r_way_valid[r_work.set_idx][victim] <= 1'b1;
            r_last_fill[r_work.set_idx]         <= victim;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= (r_state == B_LOOK);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == B_LOOK) begin
            r_data_byte   <= sel_word[{r_work.offset, BYTE_SHIFT'(0)} +: BYTE_BITS];
            r_from_memory <= miss;
        end
    end

    assign o_strobe      = r_strobe;
    assign o_data_byte   = r_data_byte;
    assign o_from_memory = r_from_memory;

    // checks
    a_strobe_after_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state == B_LOOK)) else $error("result without lookup");
    a_no_double_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_LOOK) |-> !(hit0 && hit1)) else $error("tag present in both ways");
    a_fill_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_from_memory) |-> (r_way_valid[r_work.set_idx] != 2'b00))
        else $error("miss left set without a valid way");

endmodule

// File: sv/two_way_cache_byte_read.sv
// top level of the two-way set-associative byte read cache
// depends on twcbr_pkg, twcbr_front, twcbr_queue, twcbr_back
//
//  channel   handshake              payload
//  request   start & !busy          i_phys_address, i_memory_word
//  result    o_strobe (one cycle)   o_data_byte, o_from_memory
//
// the back end handles each request in two steps: the first reads both ways' tag and
// data arrays at the set, the second compares, selects the byte and fills on a miss;
// it pops the next request from the queue only once it is back in idle.
// on an idle block a request passes the staging register, the queue, the back end's
// work register and array read and the result register before the strobe rises.
// synchronous active-low reset clears valid bits, replacement order and control.
// busy rises only when the staging register and the two-entry queue are full;
// the receiver cannot stall the result.
module two_way_cache_byte_read (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [19:0] i_phys_address,
    input  logic [31:0] i_memory_word,
    output logic        o_strobe,
    output logic [7:0]  o_data_byte,
    output logic        o_from_memory
);
    import twcbr_pkg::*;

    t_req f_req;
    t_req q_data;
    logic f_push;
    logic q_full;
    logic q_empty;
    logic b_pop;

    // request decode and staging
    twcbr_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_phys_address (i_phys_address),
        .i_memory_word  (i_memory_word),
        .i_q_full       (q_full),
        .o_busy         (busy),
        .o_push         (f_push),
        .o_req          (f_req)
    );

    // decoupling queue
    twcbr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  (f_req),
        .i_pop   (b_pop),
        .o_data  (q_data),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // lookup, fill and result
    twcbr_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .i_q_data      (q_data),
        .o_pop         (b_pop),
        .o_strobe      (o_strobe),
        .o_data_byte   (o_data_byte),
        .o_from_memory (o_from_memory)
    );

endmodule
